### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while arst_n is low.
`define MMSL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, for a check that only applies while the output side holds a word.
`define MMSL_ASSERT_OUT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> prop) \
		else $error(msg);

`endif

### design/mmsl_pkg.sv
`default_nettype none

package mmsl_pkg;

	localparam logic [7:0]  WORD_TAG      = 8'h2F;
	localparam logic [7:0]  BUTTONS_RESET = 8'hFF;
	localparam logic [15:0] PERIOD_RESET  = 16'd7000;
	localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;
	localparam int          OUT_DEPTH     = 4;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_LATCH  = 2'd1,
		OP_TICK   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} out_entry_t;

	// one or two words written into the output queue in one cycle
	typedef struct packed {
		logic       one;
		logic       two;
		out_entry_t first;
		out_entry_t second;
	} push_t;

	function automatic logic [31:0] build_word(logic [15:0] sx, logic [15:0] sy,
		logic [7:0] btn);
		logic [15:0] xi;
		logic [15:0] yi;
		xi = ~sx;
		yi = ~sy;
		return {WORD_TAG, btn, xi[8:1], yi[8:1]};
	endfunction

endpackage

`default_nettype wire

### design/mmsl_out_fifo.sv
`default_nettype none

module mmsl_out_fifo #(
	parameter int DEPTH = mmsl_pkg::OUT_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mmsl_pkg::push_t    push,
	output logic                    room2,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mmsl_pkg::out_entry_t    out_entry
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	mmsl_pkg::out_entry_t mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q, wr_next;
	logic [CW-1:0] count_q;
	logic          pop;

	function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign room2     = (count_q <= CW'(DEPTH - 2));
	assign out_entry = mem[rd_ptr_q];
	assign wr_next   = wrap_inc(wr_ptr_q);

	always_ff @(posedge clk) begin
		if (push.one) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.two) begin
			mem[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.two) begin
				wr_ptr_q <= wrap_inc(wr_next);
			end else if (push.one) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.one) + CW'(push.two) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

### design/mouse_motion_scan_latch.sv
`default_nettype none

// Mouse motion accumulator for a console mouse port. Each accepted word on the
// input side is a mouse report (adds signed dx/dy to 16-bit wrapping totals and
// records buttons), a scan latch edge (locks the snapshot) or a 1 us tick
// (advances the unlock timer; past unlock_period_us it debits the reported
// motion and unlocks). Every event that pushes a port word shows it on the
// output side as {0x2F, buttons, ~x[8:1], ~y[8:1]}; last marks the final word
// of an event, so a timeout gives two words (first with last = 0). Rate: one
// input word per cycle. An accepted word is held in the input register, is
// evaluated there against the block state and its words land in a small
// output queue (OUT_DEPTH entries), visible on the cycle after. The input
// stalls only while the queue has fewer than two free slots; the output drains
// one word per cycle while out_ready is high. unlock_period_us may be written
// whenever the block is idle and takes effect on the next tick.
module mouse_motion_scan_latch #(
	parameter int OUT_DEPTH = mmsl_pkg::OUT_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_wdata,
	// input words
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         button_bits,
	input  wire logic signed [7:0]  move_x,
	input  wire logic signed [7:0]  move_y,
	// output words
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             port_word,
	output logic                    last
);

	// input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  btn_s1;
	logic [7:0]  mx_s1, my_s1;

	// block state
	logic [15:0] period_q;
	logic [15:0] total_x_q, total_y_q;
	logic [15:0] snap_x_q, snap_y_q;
	logic [7:0]  latest_btn_q, snap_btn_q;
	logic        locked_q, taken_q;
	logic [16:0] elapsed_q;

	// next state
	logic [15:0] total_x_d, total_y_d, snap_x_d, snap_y_d;
	logic [7:0]  latest_btn_d, snap_btn_d;
	logic        locked_d, taken_d;
	logic [16:0] elapsed_d;

	logic [15:0] sum_x, sum_y;
	logic [16:0] elapsed_inc;
	logic [31:0] word_now;
	logic        advance, room2;
	mmsl_pkg::push_t      push;
	mmsl_pkg::out_entry_t out_entry;

	assign advance  = valid_s1 && room2;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1  <= opcode;
			btn_s1 <= button_bits;
			mx_s1  <= move_x;
			my_s1  <= move_y;
		end
	end

	assign sum_x       = total_x_q + {{8{mx_s1[7]}}, mx_s1};
	assign sum_y       = total_y_q + {{8{my_s1[7]}}, my_s1};
	assign elapsed_inc = (elapsed_q == mmsl_pkg::ELAPSED_MAX) ? elapsed_q
	                     : elapsed_q + 17'd1;
	// the held word always matches the current snapshot
	assign word_now    = mmsl_pkg::build_word(snap_x_q, snap_y_q, snap_btn_q);

	always_comb begin
		total_x_d    = total_x_q;
		total_y_d    = total_y_q;
		snap_x_d     = snap_x_q;
		snap_y_d     = snap_y_q;
		latest_btn_d = latest_btn_q;
		snap_btn_d   = snap_btn_q;
		locked_d     = locked_q;
		taken_d      = taken_q;
		elapsed_d    = elapsed_q;
		push         = '0;
		push.first   = '{word: word_now, last: 1'b1};
		case (mmsl_pkg::opcode_t'(op_s1))
			mmsl_pkg::OP_REPORT: begin
				total_x_d    = sum_x;
				total_y_d    = sum_y;
				latest_btn_d = btn_s1;
				if (!locked_q) begin
					snap_x_d   = sum_x;
					snap_y_d   = sum_y;
					snap_btn_d = btn_s1;
					push.one   = 1'b1;
					push.first = '{word: mmsl_pkg::build_word(sum_x, sum_y, btn_s1),
					               last: 1'b1};
				end
			end
			mmsl_pkg::OP_LATCH: begin
				// latch while locked is a repeated scan: ignored
				if (!locked_q) begin
					locked_d  = 1'b1;
					taken_d   = 1'b1;
					elapsed_d = '0;
					push.one  = 1'b1;
				end
			end
			mmsl_pkg::OP_TICK: begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc > {1'b0, period_q}) begin
					// timeout: word before debit, then word after unlock
					push.one   = 1'b1;
					push.two   = 1'b1;
					push.first = '{word: word_now, last: 1'b0};
					if (taken_q) begin
						total_x_d  = total_x_q - snap_x_q;
						total_y_d  = total_y_q - snap_y_q;
						snap_x_d   = '0;
						snap_y_d   = '0;
						snap_btn_d = latest_btn_q;
						taken_d    = 1'b0;
					end
					locked_d    = 1'b0;
					elapsed_d   = '0;
					push.second = '{word: mmsl_pkg::build_word(snap_x_d, snap_y_d, snap_btn_d),
					                last: 1'b1};
				end
			end
			default: begin
				// unused opcode: no effect
			end
		endcase
		if (!advance) begin
			push.one = 1'b0;
			push.two = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= mmsl_pkg::PERIOD_RESET;
			total_x_q    <= '0;
			total_y_q    <= '0;
			snap_x_q     <= '0;
			snap_y_q     <= '0;
			latest_btn_q <= mmsl_pkg::BUTTONS_RESET;
			snap_btn_q   <= mmsl_pkg::BUTTONS_RESET;
			locked_q     <= 1'b0;
			taken_q      <= 1'b0;
			elapsed_q    <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (advance) begin
				total_x_q    <= total_x_d;
				total_y_q    <= total_y_d;
				snap_x_q     <= snap_x_d;
				snap_y_q     <= snap_y_d;
				latest_btn_q <= latest_btn_d;
				snap_btn_q   <= snap_btn_d;
				locked_q     <= locked_d;
				taken_q      <= taken_d;
				elapsed_q    <= elapsed_d;
			end
		end
	end

	mmsl_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room2    (room2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_entry(out_entry)
	);

	assign port_word = out_entry.word;
	assign last      = out_entry.last;

endmodule

`default_nettype wire

### design/mmsl_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mmsl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] port_word,
	input wire logic        last
);

	`MMSL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output word dropped")
	`MMSL_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(port_word) && $stable(last), "stalled word changed")
	`MMSL_ASSERT_OUT(a_word_tag, port_word[31:24] == 8'h2F, "word tag wrong")
	`MMSL_ASSERT(a_pair_ready, out_valid && out_ready && !last |=> out_valid, "second word of timeout missing")

endmodule

bind mouse_motion_scan_latch mmsl_checker u_mmsl_checker (.*);

`default_nettype wire
